FILE: rtl/core/sece_pkg.sv
`default_nettype none
package sece_pkg;

	localparam int SELECT_LINES_DEF = 10;
	localparam int WORD_BITS_DEF    = 14;
	localparam int CODE_W           = 3;
	localparam int TICK_W           = 16;

	localparam logic [TICK_W-1:0] PROGRAM_TICKS_RESET = 16'd15;
	localparam logic [TICK_W-1:0] ELAPSED_MAX         = 16'hffff;

	// command line codes
	localparam logic [CODE_W-1:0] CMD_ERASE     = 3'd2;
	localparam logic [CODE_W-1:0] CMD_ADDRESS   = 3'd3;
	localparam logic [CODE_W-1:0] CMD_READ      = 3'd4;
	localparam logic [CODE_W-1:0] CMD_SHIFT_OUT = 3'd5;
	localparam logic [CODE_W-1:0] CMD_WRITE     = 3'd6;
	localparam logic [CODE_W-1:0] CMD_DATA      = 3'd7;

endpackage
`default_nettype wire

FILE: rtl/core/serial_earom_command_engine_core.sv
// Serial word store with command engine, SELECT_LINES*SELECT_LINES words of WORD_BITS bits.
// Input channel (in_valid / in_stall) carries one item per transfer: kind (time tick or
// command clock edge), the 3-bit command code and the serial data_in level.
// Output channel (out_valid / out_stall) returns exactly one result per item: data_line
// and the select error, applied and late flags.
// Config: cfg_write with cfg_data sets the erase/write hold time in ticks; write only
// while the block is idle.
// Flow: a tick or an edge that does not touch the word store passes through res_q and
// the deliver state into the output register, and the next item is taken once the
// block is back in idle. A read, or a timed write, walks every word through the memory's
// read and write ports, then drains and delivers its result.
// A timed erase clears the per-word valid flags of the selected words.
// One item is in work at a time; in_stall is high from the cycle after a transfer in
// until the result sits in the output register.
// The output register holds a result while out_stall is high; the next item may already
// be taken and worked on, and its result waits until the register frees.
// Reset (arst_n low) empties the word store by clearing all valid flags, clears the
// address and data registers and the pending commands, and sets the hold time to 15.
`default_nettype none
module serial_earom_command_engine_core #(
	parameter int SELECT_LINES = sece_pkg::SELECT_LINES_DEF,
	parameter int WORD_BITS    = sece_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic [sece_pkg::TICK_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        kind,
	input  wire logic [sece_pkg::CODE_W-1:0] code,
	input  wire logic                        data_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             data_line,
	output logic                             select_error,
	output logic                             write_applied,
	output logic                             erase_applied,
	output logic                             write_late,
	output logic                             erase_late
);
	import sece_pkg::*;

	localparam int WORD_COUNT = SELECT_LINES * SELECT_LINES;
	localparam int ADDR_BITS  = 2 * SELECT_LINES;
	localparam int LINE_W     = $clog2(SELECT_LINES);
	localparam int IDX_W      = $clog2(WORD_COUNT);
	localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(SELECT_LINES - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DELIVER} state_t;

	typedef struct packed {
		logic line;
		logic sel_err;
		logic w_app;
		logic e_app;
		logic w_late;
		logic e_late;
	} result_t;

	state_t                 state_q;
	result_t                res_q;
	result_t                out_q;
	logic                   out_valid_q;
	logic [TICK_W-1:0]      ticks_q;
	logic [WORD_BITS-1:0]   ds_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic                   wp_q;
	logic                   ep_q;
	logic [TICK_W-1:0]      we_q;
	logic [TICK_W-1:0]      ee_q;
	logic [WORD_COUNT-1:0]  valid_q;
	logic                   wr_q;
	logic                   rd_q;
	logic [WORD_BITS-1:0]   acc_q;
	logic [LINE_W-1:0]      t_q;
	logic [LINE_W-1:0]      u_q;
	logic [IDX_W-1:0]       idx_q;
	logic [WORD_BITS-1:0]   wd_q;
	logic [ADDR_BITS-1:0]   wa_q;

	logic                   vld_s1;
	logic                   sel_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [WORD_BITS-1:0]   rdata_s1;

	logic [WORD_BITS-1:0]   word_mem [WORD_COUNT];

	logic [WORD_COUNT-1:0]  sel_vec;
	logic                   w_due;
	logic                   e_due;
	logic                   one_sel;
	logic                   line_now;
	logic                   hit_wr;
	logic [WORD_BITS-1:0]   old_word;
	logic [WORD_BITS-1:0]   new_word;
	logic [WORD_BITS-1:0]   acc_next;
	result_t                res_now;

	for (genvar t = 0; t < SELECT_LINES; t++) begin : g_tens
		for (genvar u = 0; u < SELECT_LINES; u++) begin : g_units
			assign sel_vec[t*SELECT_LINES+u] = addr_q[SELECT_LINES+t] & addr_q[u];
		end
	end

	always_comb begin
		w_due   = wp_q && (we_q >= ticks_q);
		e_due   = ep_q && (ee_q >= ticks_q);
		one_sel = $onehot(addr_q[ADDR_BITS-1:SELECT_LINES]) && $onehot(addr_q[SELECT_LINES-1:0]);
		// shift out moves the register on an edge, so the line sees the bit below the top
		line_now = data_in;
		if (code == CMD_SHIFT_OUT)
			line_now = data_in | (kind ? ds_q[WORD_BITS-2] : ds_q[WORD_BITS-1]);
		res_now      = '0;
		res_now.line = line_now;
		if (kind) begin
			res_now.w_app   = w_due;
			res_now.e_app   = e_due;
			res_now.w_late  = (code != CMD_WRITE) && wp_q && !w_due;
			res_now.e_late  = (code != CMD_ERASE) && ep_q && !e_due;
			res_now.sel_err = (w_due || e_due || code == CMD_READ) && !one_sel;
		end
		old_word = valid_q[idx_s1] ? rdata_s1 : '0;
		new_word = wr_q ? (old_word | wd_q) : old_word;
		hit_wr   = vld_s1 && sel_s1 && wr_q;
		acc_next = (vld_s1 && sel_s1 && rd_q) ? (acc_q | new_word) : acc_q;
	end

	// word store: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		rdata_s1 <= word_mem[idx_q];
		if (hit_wr)
			word_mem[idx_s1] <= new_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ticks_q     <= PROGRAM_TICKS_RESET;
			ds_q        <= '0;
			addr_q      <= '0;
			wp_q        <= 1'b0;
			ep_q        <= 1'b0;
			we_q        <= '0;
			ee_q        <= '0;
			valid_q     <= '0;
			wr_q        <= 1'b0;
			rd_q        <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			if (cfg_write)
				ticks_q <= cfg_data;
			if (out_valid_q && !out_stall && state_q != ST_DELIVER)
				out_valid_q <= 1'b0;

			vld_s1 <= (state_q == ST_WALK);
			idx_s1 <= idx_q;
			sel_s1 <= wa_q[SELECT_LINES + int'(t_q)] & wa_q[u_q];
			if (hit_wr)
				valid_q[idx_s1] <= 1'b1;
			acc_q <= (state_q == ST_IDLE) ? '0 : acc_next;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_q <= res_now;
						if (!kind) begin
							state_q <= ST_DELIVER;
							if (wp_q && we_q != ELAPSED_MAX)
								we_q <= we_q + 1'b1;
							if (ep_q && ee_q != ELAPSED_MAX)
								ee_q <= ee_q + 1'b1;
						end else begin
							if (code != CMD_WRITE) begin
								wp_q <= 1'b0;
								we_q <= '0;
							end else if (!wp_q) begin
								wp_q <= 1'b1;
								we_q <= '0;
							end
							if (code != CMD_ERASE) begin
								ep_q <= 1'b0;
								ee_q <= '0;
							end else if (!ep_q) begin
								ep_q <= 1'b1;
								ee_q <= '0;
							end
							if (e_due)
								valid_q <= valid_q & ~sel_vec;
							case (code)
								CMD_ADDRESS:   addr_q <= {addr_q[ADDR_BITS-2:0], data_in};
								CMD_SHIFT_OUT: ds_q   <= {ds_q[WORD_BITS-2:0], 1'b0};
								CMD_DATA:      ds_q   <= {ds_q[WORD_BITS-2:0], data_in};
								default: ;
							endcase
							// the walk sees address and data as they stood before this edge
							wd_q  <= ds_q;
							wa_q  <= addr_q;
							// write completes before any read on the same edge
							wr_q  <= w_due;
							rd_q  <= (code == CMD_READ);
							t_q   <= '0;
							u_q   <= '0;
							idx_q <= '0;
							if (w_due || code == CMD_READ)
								state_q <= ST_WALK;
							else
								state_q <= ST_DELIVER;
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (u_q == LINE_LAST) begin
						u_q <= '0;
						t_q <= t_q + 1'b1;
						if (t_q == LINE_LAST)
							state_q <= ST_DRAIN;
					end else begin
						u_q <= u_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (rd_q)
						ds_q <= acc_next;
					state_q <= ST_DELIVER;
				end
				ST_DELIVER: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign data_line     = out_q.line;
	assign select_error  = out_q.sel_err;
	assign write_applied = out_q.w_app;
	assign erase_applied = out_q.e_app;
	assign write_late    = out_q.w_late;
	assign erase_late    = out_q.e_late;

endmodule
`default_nettype wire

FILE: rtl/core/sece_checker.sv
`default_nettype none
module sece_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic data_line,
	input wire logic select_error,
	input wire logic write_applied,
	input wire logic erase_applied,
	input wire logic write_late,
	input wire logic erase_late
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_line) && $stable(select_error)
			&& $stable(write_applied) && $stable(erase_applied)
			&& $stable(write_late) && $stable(erase_late))
		else $error("stalled result changed");

	// only one of erase and write can be pending on an edge
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_applied && erase_applied) && !(write_late && erase_late))
		else $error("erase and write both reported");

	// a command is either complete or late, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(write_applied && write_late) && !(erase_applied && erase_late))
		else $error("applied and late together");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("transfer taken while busy");

endmodule

bind serial_earom_command_engine_core sece_checker u_sece_checker (.*);
`default_nettype wire
